// ----- design/rpa_pkg.sv -----
// shared constants and elaboration-time functions for the recoil pressure acceleration block
package rpa_pkg;

    localparam int RPA_FRACTION_BITS_DEFAULT = 16;

    // log2(e) with 32 fraction bits
    localparam logic [32:0] LOG2E_Q32 = 33'd6196328019;

    // quotient width of the force division, clamp at 2^34
    localparam int QUO_BITS = 35;

    localparam int CFG_INDEX_BITS = 8;

    // raw register reset values (1.0, 1.0, 0.0 in Q16.16)
    localparam logic [31:0] TB_RESET   = 32'h0001_0000;
    localparam logic [31:0] PFAC_RESET = 32'h0001_0000;
    localparam logic [31:0] TFAC_RESET = 32'h0000_0000;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_BOILING_TEMPERATURE = 8'd0,
        REG_PRESSURE_FACTOR     = 8'd1,
        REG_TEMPERATURE_FACTOR  = 8'd2
    } cfg_reg_t;

    // integer square root, bit pair at a time
    function automatic logic [63:0] isqrt64(input logic [63:0] v);
        logic [63:0] x;
        logic [63:0] r;
        logic [63:0] b;
        x = v;
        r = '0;
        b = 64'd1 << 62;
        for (int i = 0; i < 32; i++) begin
            if (x >= r + b) begin
                x = x - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    // 2^(2^-k) with 30 fraction bits, k repeated square roots of 2.0
    function automatic logic [31:0] exp_root(input int k);
        logic [63:0] t;
        t = 64'd1 << 31;
        for (int i = 1; i <= k; i++) begin
            t = isqrt64(t << 30);
        end
        return t[31:0];
    endfunction

endpackage

// ----- design/recoil_pressure_acceleration.sv -----
// recoil pressure acceleration kernel: pipelined exp, pressure and force update per particle
//
// usage
//   s_* channel: one particle per transaction (density, temperature, gradient,
//   normal, acceleration), accepted when s_tvalid and s_tready are both high
//   m_* channel: one result per particle, updated acceleration in m_tdata and
//   the applied / saturated / zero density flags in m_tuser
//   cfg_* channel: register writes (boiling temperature, pressure factor,
//   temperature factor), always ready, write only while the block is idle
// throughput: one particle per cycle while s_tready is high; every step of the math is
//   its own stage, from the bit-per-stage exponent divider (FRACTION_BITS+6 stages)
//   over the FRACTION_BITS multiply stages of the exponential (Q16.16 data by
//   default) to the 35 stage force divider
// reset: aresetn low clears all valid bits and the output buffer and loads
//   the register defaults (Tb = 1.0, pfac = 1.0, tfac = 0.0)
// stall: a two entry output buffer sits behind the pipeline; while the
//   receiver stalls the pipeline keeps moving until the spare entry fills,
//   then s_tready drops and the whole pipeline freezes, losing nothing
module recoil_pressure_acceleration
    import rpa_pkg::*;
#(
    parameter int FRACTION_BITS = RPA_FRACTION_BITS_DEFAULT
) (
    input  logic                      aclk,
    input  logic                      aresetn,

    input  logic                      s_tvalid,
    output logic                      s_tready,
    // density, temperature, gradient_x, gradient_y, gradient_z,
    // normal_x, normal_y, normal_z, accel_x, accel_y, accel_z (32 bits each)
    input  logic [351:0]              s_tdata,

    output logic                      m_tvalid,
    input  logic                      m_tready,
    // new_accel_x, new_accel_y, new_accel_z (32 bits each)
    output logic [95:0]               m_tdata,
    // applied, saturated, zero_density_error
    output logic [2:0]                m_tuser,

    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [31:0]               cfg_data
);

    localparam int F   = FRACTION_BITS;
    localparam int K   = F + 6;       // exponent quotient bits
    localparam int RW1 = 70 + F;      // exponent divider remainder width
    localparam int PW  = 64 - F;      // pressure width
    localparam int PRW = 96 - F;      // pressure times gradient width
    localparam int SH  = 30 - F;

    // stage map
    localparam int ST_C   = 2;
    localparam int ST_Y   = K + 3;
    localparam int ST_E   = ST_Y + F + 1;
    localparam int ST_P   = ST_E + 1;
    localparam int ST_SUM = ST_P + 2;
    localparam int ST_OV2 = ST_SUM + 1;
    localparam int LAST   = ST_OV2 + QUO_BITS;
    localparam int NST    = LAST + 1;

    localparam logic [K-1:0]        X_CAP = {1'b1, {(F + 5){1'b0}}};
    localparam logic [QUO_BITS-1:0] Q_CAP = {1'b1, {(QUO_BITS - 1){1'b0}}};
    localparam logic signed [36:0]  SUM_MAX = 37'sd2147483647;
    localparam logic signed [36:0]  SUM_MIN = -37'sd2147483648;

    typedef struct packed {
        logic [2:0][31:0] accel;
        logic [2:0][31:0] gmag;
        logic [2:0]       gneg;
        logic [31:0]      rho;
        logic             due;
        logic             zerr;
        logic             esat;
    } side_t;

    typedef struct packed {
        logic [RW1-1:0] rem;
        logic [K-1:0]   quo;
        logic [63:0]    den;
        logic           ovf;
    } d1_t;

    typedef struct packed {
        logic [31:0]  m;
        logic [K-1:0] y;
    } ex_t;

    typedef struct packed {
        logic [PRW-1:0]      rem;
        logic [QUO_BITS-1:0] quo;
        logic                ovf;
    } d2_t;

    typedef struct packed {
        logic [95:0] data;
        logic [2:0]  user;
    } res_t;

    // configuration registers
    logic [31:0] tb_reg;
    logic [31:0] pfac_reg;
    logic [31:0] tfac_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tb_reg   <= TB_RESET;
            pfac_reg <= PFAC_RESET;
            tfac_reg <= TFAC_RESET;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_BOILING_TEMPERATURE: tb_reg   <= cfg_data;
                REG_PRESSURE_FACTOR:     pfac_reg <= cfg_data;
                REG_TEMPERATURE_FACTOR:  tfac_reg <= cfg_data;
                default: ;  // unknown index, write dropped
            endcase
        end
    end

    // global advance: the pipeline stops only when the spare output entry is full
    logic skid_valid_reg;
    logic en;
    assign en       = !skid_valid_reg;
    assign s_tready = en;

    logic [NST-1:0] vld_reg;
    side_t          side_reg [NST];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[NST-2:0], s_tvalid};
        end
    end

    // stage 0: unpack, classify, gradient magnitudes
    side_t       side_in;
    logic [31:0] in_temp;
    logic        normal_nz;
    logic        hot;

    always_comb begin
        in_temp   = s_tdata[63:32];
        normal_nz = |s_tdata[255:160];
        hot       = in_temp > tb_reg;
        side_in.rho  = s_tdata[31:0];
        side_in.due  = normal_nz && hot && (s_tdata[31:0] != 32'd0);
        side_in.zerr = normal_nz && hot && (s_tdata[31:0] == 32'd0);
        side_in.esat = 1'b0;
        for (int c = 0; c < 3; c++) begin
            side_in.accel[c] = s_tdata[256 + 32*c +: 32];
            side_in.gneg[c]  = s_tdata[64 + 32*c + 31];
            side_in.gmag[c]  = s_tdata[64 + 32*c + 31] ? 32'(-s_tdata[64 + 32*c +: 32])
                                                      : s_tdata[64 + 32*c +: 32];
        end
    end

    logic [31:0] diff_reg;
    logic [31:0] temp_a_reg;
    logic [63:0] num_reg;
    logic [63:0] den_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            side_reg[0] <= side_in;
            diff_reg    <= in_temp - tb_reg;
            temp_a_reg  <= in_temp;
            // stage 1: numerator tfac*(T-Tb) and divisor T*Tb
            num_reg     <= 64'(tfac_reg) * 64'(diff_reg);
            den_reg     <= 64'(temp_a_reg) * 64'(tb_reg);
        end
    end

    // exponential saturation, joins the side band at its stage
    logic esat_calc;

    // side band travels with the item, the exponential flag joins at its stage
    for (genvar j = 1; j < NST; j++) begin : g_side
        if (j == ST_E) begin : g_esat
            side_t side_e;
            always_comb begin
                side_e      = side_reg[j-1];
                side_e.esat = esat_calc;
            end
            always_ff @(posedge aclk) begin
                if (en) begin
                    side_reg[j] <= side_e;
                end
            end
        end else begin : g_copy
            always_ff @(posedge aclk) begin
                if (en) begin
                    side_reg[j] <= side_reg[j-1];
                end
            end
        end
    end

    // exponent divider: overflow test, then one quotient bit per stage
    d1_t d1_reg [K+1];

    always_ff @(posedge aclk) begin
        if (en) begin
            d1_reg[0].rem <= RW1'(num_reg) << F;
            d1_reg[0].quo <= '0;
            d1_reg[0].den <= den_reg;
            d1_reg[0].ovf <= {6'd0, num_reg} >= {den_reg, 6'd0};
        end
    end

    for (genvar j = 0; j < K; j++) begin : g_div1
        localparam int B = K - 1 - j;
        logic [RW1-1:0] dsh;
        d1_t            d1_next;
        assign dsh = RW1'(d1_reg[j].den) << B;
        always_comb begin
            d1_next = d1_reg[j];
            if (d1_reg[j].rem >= dsh) begin
                d1_next.rem    = d1_reg[j].rem - dsh;
                d1_next.quo[B] = 1'b1;
            end
        end
        always_ff @(posedge aclk) begin
            if (en) begin
                d1_reg[j+1] <= d1_next;
            end
        end
    end

    // clamp exponent and convert to base 2
    logic [K-1:0]    x_clamped;
    logic [K+32:0]   y_prod;
    ex_t             ex_reg [F+1];

    assign x_clamped = (d1_reg[K].ovf || d1_reg[K].quo > X_CAP) ? X_CAP : d1_reg[K].quo;
    assign y_prod    = (K + 33)'(x_clamped) * (K + 33)'(LOG2E_Q32);

    always_ff @(posedge aclk) begin
        if (en) begin
            ex_reg[0].m <= 32'd1 << 30;
            ex_reg[0].y <= y_prod[32 +: K];
        end
    end

    // fraction of 2^y: one root multiply per fraction bit
    for (genvar k = 1; k <= F; k++) begin : g_exp
        localparam logic [31:0] TK = exp_root(k);
        logic [63:0] mt;
        assign mt = 64'(ex_reg[k-1].m) * 64'(TK) + (64'd1 << 29);
        always_ff @(posedge aclk) begin
            if (en) begin
                ex_reg[k].y <= ex_reg[k-1].y;
                ex_reg[k].m <= ex_reg[k-1].y[F-k] ? mt[61:30] : ex_reg[k-1].m;
            end
        end
    end

    // integer part: shift, round to F fraction bits, saturate
    logic [4:0]  exp_n;
    logic        exp_nsat;
    logic [63:0] exp_sh;
    logic [63:0] exp_e64;
    logic        exp_ovf;
    logic [31:0] e_reg;
    logic [PW-1:0] p_reg;
    logic [63:0] p_full;

    assign exp_n     = ex_reg[F].y[F+4:F];
    assign exp_nsat  = ex_reg[F].y[K-1];
    assign exp_sh    = 64'(ex_reg[F].m) << exp_n;
    assign exp_e64   = (exp_sh + (64'd1 << (SH - 1))) >> SH;
    assign exp_ovf   = |exp_e64[63:32];
    assign esat_calc = exp_nsat || exp_ovf;
    assign p_full    = 64'(pfac_reg) * 64'(e_reg);

    always_ff @(posedge aclk) begin
        if (en) begin
            e_reg <= (exp_nsat || exp_ovf) ? 32'hFFFF_FFFF : exp_e64[31:0];
            // pressure
            p_reg <= p_full[63:F];
        end
    end

    // pressure times gradient magnitude, split into two partial products
    logic [63:0]    lo_reg   [3];
    logic [PW-1:0]  hi_reg   [3];
    logic [PRW-1:0] prod_reg [3];
    d2_t            d2_reg   [3][QUO_BITS+1];

    for (genvar c = 0; c < 3; c++) begin : g_comp
        always_ff @(posedge aclk) begin
            if (en) begin
                lo_reg[c]   <= 64'(p_reg[31:0]) * 64'(side_reg[ST_P].gmag[c]);
                hi_reg[c]   <= PW'(p_reg[PW-1:32]) * PW'(side_reg[ST_P].gmag[c]);
                prod_reg[c] <= (PRW'(hi_reg[c]) << 32) + PRW'(lo_reg[c]);
                d2_reg[c][0].rem <= prod_reg[c];
                d2_reg[c][0].quo <= '0;
                d2_reg[c][0].ovf <= prod_reg[c] >= (PRW'(side_reg[ST_SUM].rho) << QUO_BITS);
            end
        end

        // force divider by density, one quotient bit per stage
        for (genvar j = 0; j < QUO_BITS; j++) begin : g_div2
            localparam int B = QUO_BITS - 1 - j;
            logic [PRW-1:0] dsh;
            d2_t            d2_next;
            assign dsh = PRW'(side_reg[ST_OV2 + j].rho) << B;
            always_comb begin
                d2_next = d2_reg[c][j];
                if (d2_reg[c][j].rem >= dsh) begin
                    d2_next.rem    = d2_reg[c][j].rem - dsh;
                    d2_next.quo[B] = 1'b1;
                end
            end
            always_ff @(posedge aclk) begin
                if (en) begin
                    d2_reg[c][j+1] <= d2_next;
                end
            end
        end
    end

    // final update: clamp quotient, add or subtract, saturate to 32 bits
    res_t                res_new;
    logic [QUO_BITS-1:0] qc;
    logic signed [36:0]  a37;
    logic signed [36:0]  sum37;
    logic [95:0]         upd;
    logic                sat_any;

    always_comb begin
        sat_any = side_reg[LAST].esat;
        upd     = '0;
        for (int c = 0; c < 3; c++) begin
            qc = (d2_reg[c][QUO_BITS].ovf || d2_reg[c][QUO_BITS].quo > Q_CAP)
                 ? Q_CAP : d2_reg[c][QUO_BITS].quo;
            a37 = {{5{side_reg[LAST].accel[c][31]}}, side_reg[LAST].accel[c]};
            if (side_reg[LAST].gneg[c]) begin
                sum37 = a37 + signed'({2'b00, qc});
            end else begin
                sum37 = a37 - signed'({2'b00, qc});
            end
            if (sum37 > SUM_MAX) begin
                upd[32*c +: 32] = 32'h7FFF_FFFF;
                sat_any         = 1'b1;
            end else if (sum37 < SUM_MIN) begin
                upd[32*c +: 32] = 32'h8000_0000;
                sat_any         = 1'b1;
            end else begin
                upd[32*c +: 32] = sum37[31:0];
            end
        end
        if (side_reg[LAST].due) begin
            res_new.data = upd;
            res_new.user = {1'b0, sat_any, 1'b1};
        end else begin
            res_new.data = side_reg[LAST].accel;
            res_new.user = {side_reg[LAST].zerr, 2'b00};
        end
    end

    // output register plus spare entry
    logic m_valid_reg;
    res_t m_res_reg;
    res_t skid_res_reg;
    logic push;
    logic m_valid_next;
    logic skid_valid_next;
    logic load_new;
    logic load_skid;
    logic fill_skid;

    assign push = en && vld_reg[LAST];

    always_comb begin
        m_valid_next    = m_valid_reg;
        skid_valid_next = skid_valid_reg;
        load_new        = 1'b0;
        load_skid       = 1'b0;
        fill_skid       = 1'b0;
        if (!m_valid_reg) begin
            load_new     = push;
            m_valid_next = push;
        end else if (m_tready) begin
            if (skid_valid_reg) begin
                load_skid       = 1'b1;
                skid_valid_next = 1'b0;
            end else begin
                load_new     = push;
                m_valid_next = push;
            end
        end else if (push) begin
            fill_skid       = 1'b1;
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg    <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            m_valid_reg    <= m_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_new) begin
            m_res_reg <= res_new;
        end else if (load_skid) begin
            m_res_reg <= skid_res_reg;
        end
        if (fill_skid) begin
            skid_res_reg <= res_new;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_res_reg.data;
    assign m_tuser  = m_res_reg.user;

`ifndef SYNTHESIS
    // spare entry is only used behind a held output
    a_skid_behind_output: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> m_valid_reg)
        else $error("spare output entry full while output empty");

    // a full spare entry freezes the pipeline
    a_pipe_frozen: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn) && $past(skid_valid_reg) |-> vld_reg == $past(vld_reg))
        else $error("pipeline moved while output buffer full");

    // saturation is only reported on applied results
    a_sat_needs_applied: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[1] |-> m_tuser[0])
        else $error("saturated flag without applied");

    // zero density and applied exclude each other
    a_zerr_not_applied: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tuser[0] && m_tuser[2]))
        else $error("applied and zero density error together");
`endif

endmodule
